// ===== hdl/mmpp_pkg.sv =====
// ----------------------------------------------------------------------------
// mmpp_pkg
// shared constants and types of the min/max peak pyramid builder
// ----------------------------------------------------------------------------
package mmpp_pkg;

  // frames per level-0 window, level-0 pairs per level-1 pair and so on
  localparam int BASE_STRIDE = 32;
  localparam int FOLD_FACTOR = 32;
  localparam int LEVEL_COUNT = 3;

  localparam int WFILL_W = $clog2(BASE_STRIDE);
  localparam int FFILL_W = $clog2(FOLD_FACTOR);
  localparam int POS_W   = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

  localparam int SAMPLE_W = 24;
  localparam int QVAL_W   = 16;
  localparam int LEVEL_W  = 2;
  localparam int CHAN_W   = 2;

  // channel setting that renders the left channel alone
  localparam logic [CHAN_W-1:0] CHAN_ONE   = 2'd1;
  localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [QVAL_W-1:0]   qval_t;

  // quantized extremes of both channels
  typedef struct packed {
    qval_t l_lo;
    qval_t l_hi;
    qval_t r_lo;
    qval_t r_hi;
  } pair_t;

  // window stage to fold stage
  typedef struct packed {
    logic  valid;
    logic  close;
    logic  last_frame;
    pair_t pair;
  } stage_t;

  // all results caused by one frame, level k at slot k
  typedef struct packed {
    pair_t [LEVEL_COUNT-1:0] pairs;
    logic  [POS_W-1:0]       last_idx;
  } bundle_t;

endpackage

// ===== hdl/mmpp_window.sv =====
// ----------------------------------------------------------------------------
// mmpp_window
// per-channel min/max over one base window, quantized to 16 bits on every frame
// ----------------------------------------------------------------------------
module mmpp_window (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  mmpp_pkg::sample_t sample_left_i,
  input  mmpp_pkg::sample_t sample_right_i,
  input  logic              final_frame_i,
  output mmpp_pkg::stage_t  stage_o
);
  import mmpp_pkg::*;

  localparam logic [SAMPLE_W-1:0] UNITY_Q22  = 24'd4194304;
  localparam logic [37:0]         ROUND_HALF = 38'd2097152;

  // clamp to +-1, round-half-away(|x| * 32767), restore sign
  function automatic qval_t quantize(input sample_t r);
    logic                neg;
    logic [SAMPLE_W-1:0] mag;
    logic [22:0]         cl;
    logic [37:0]         acc;
    qval_t               qs;
    neg = r[SAMPLE_W-1];
    mag = neg ? (SAMPLE_W'(~r) + 24'd1) : SAMPLE_W'(r);
    cl  = (mag > UNITY_Q22) ? UNITY_Q22[22:0] : mag[22:0];
    // times 32767 as shift and subtract
    acc = {cl, 15'd0} - {15'd0, cl} + ROUND_HALF;
    qs  = {1'b0, acc[36:22]};
    return neg ? -qs : qs;
  endfunction

  logic [WFILL_W-1:0] fill_q, fill_d;
  sample_t            min_q [2];
  sample_t            max_q [2];
  sample_t            min_d [2];
  sample_t            max_d [2];
  sample_t            smp   [2];
  logic               first;
  logic               close;

  // stage register
  logic               stage_valid_q;
  logic               close_q;
  logic               last_frame_q;
  pair_t              pair_q;

  assign stage_o = {stage_valid_q, close_q, last_frame_q, pair_q};

  always_comb begin
    smp[0] = sample_left_i;
    smp[1] = sample_right_i;
    first  = (fill_q == '0);
    for (int ch = 0; ch < 2; ch++) begin
      min_d[ch] = (first || smp[ch] < min_q[ch]) ? smp[ch] : min_q[ch];
      max_d[ch] = (first || smp[ch] > max_q[ch]) ? smp[ch] : max_q[ch];
    end
    close  = final_frame_i || (fill_q == WFILL_W'(BASE_STRIDE - 1));
    fill_d = close ? '0 : fill_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q        <= '0;
      stage_valid_q <= 1'b0;
    end else if (en_i) begin
      stage_valid_q <= valid_i;
      if (valid_i) begin
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      for (int ch = 0; ch < 2; ch++) begin
        min_q[ch] <= min_d[ch];
        max_q[ch] <= max_d[ch];
      end
      close_q      <= close;
      last_frame_q <= final_frame_i;
      pair_q.l_lo  <= quantize(min_d[0]);
      pair_q.l_hi  <= quantize(max_d[0]);
      pair_q.r_lo  <= quantize(min_d[1]);
      pair_q.r_hi  <= quantize(max_d[1]);
    end
  end

endmodule

// ===== hdl/mmpp_fold.sv =====
// ----------------------------------------------------------------------------
// mmpp_fold
// folds level-0 pairs into the upper levels and gathers one frame's results
// ----------------------------------------------------------------------------
module mmpp_fold (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  mmpp_pkg::stage_t  stage_i,
  output logic              load_o,
  output mmpp_pkg::bundle_t bundle_o
);
  import mmpp_pkg::*;

  logic [LEVEL_COUNT-1:0][FFILL_W-1:0] fill_q, fill_d;
  pair_t                               fold_q [LEVEL_COUNT];
  pair_t                               fold_d [LEVEL_COUNT];

  pair_t carry;
  pair_t nxt;
  logic  go;
  logic  first;

  assign load_o = stage_i.valid && stage_i.close;

  always_comb begin
    fill_d = fill_q;
    for (int lv = 0; lv < LEVEL_COUNT; lv++) begin
      fold_d[lv] = fold_q[lv];
      bundle_o.pairs[lv] = fold_q[lv];
    end
    carry              = stage_i.pair;
    go                 = load_o;
    first              = 1'b0;
    nxt                = stage_i.pair;
    bundle_o.pairs[0]  = stage_i.pair;
    bundle_o.last_idx  = '0;
    // each level only sees a pair when the level below emitted one
    for (int lv = 1; lv < LEVEL_COUNT; lv++) begin
      if (go) begin
        first    = (fill_q[lv] == '0);
        nxt.l_lo = (first || carry.l_lo < fold_q[lv].l_lo) ? carry.l_lo : fold_q[lv].l_lo;
        nxt.l_hi = (first || carry.l_hi > fold_q[lv].l_hi) ? carry.l_hi : fold_q[lv].l_hi;
        nxt.r_lo = (first || carry.r_lo < fold_q[lv].r_lo) ? carry.r_lo : fold_q[lv].r_lo;
        nxt.r_hi = (first || carry.r_hi > fold_q[lv].r_hi) ? carry.r_hi : fold_q[lv].r_hi;
        fold_d[lv] = nxt;
        if (stage_i.last_frame || fill_q[lv] == FFILL_W'(FOLD_FACTOR - 1)) begin
          fill_d[lv]         = '0;
          bundle_o.pairs[lv] = nxt;
          bundle_o.last_idx  = POS_W'(lv);
          carry              = nxt;
        end else begin
          fill_d[lv] = fill_q[lv] + 1'b1;
          go         = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (en_i) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int lv = 0; lv < LEVEL_COUNT; lv++) begin
        fold_q[lv] <= fold_d[lv];
      end
    end
  end

`ifndef SYNTH
  // a flushing frame leaves every upper level empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && load_o && stage_i.last_frame |=> fill_q == '0)
    else $error("fold levels not empty after final frame");

  // a flushing frame emits one result per level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o && stage_i.last_frame |-> bundle_o.last_idx == POS_W'(LEVEL_COUNT - 1))
    else $error("final frame does not flush all levels");
`endif

endmodule

// ===== hdl/mmpp_outbuf.sv =====
// ----------------------------------------------------------------------------
// mmpp_outbuf
// result register, hands out one frame's results in ascending level order
// ----------------------------------------------------------------------------
module mmpp_outbuf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  mmpp_pkg::bundle_t           bundle_i,
  input  logic                        one_channel_i,
  output logic                        en_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mmpp_pkg::LEVEL_W-1:0] pyramid_level_o,
  output mmpp_pkg::qval_t             left_low_o,
  output mmpp_pkg::qval_t             left_high_o,
  output mmpp_pkg::qval_t             right_low_o,
  output mmpp_pkg::qval_t             right_high_o,
  output logic                        last_of_run_o
);
  import mmpp_pkg::*;

  logic             valid_q;
  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] last_q;
  pair_t            pairs_q [LEVEL_COUNT];
  pair_t            cur;
  logic             at_last;

  assign at_last = (pos_q == last_q);
  // upstream moves when the buffer is empty or its last word leaves now
  assign en_o    = !valid_q || (!out_stall_i && at_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
      last_q  <= '0;
    end else if (en_o && load_i) begin
      valid_q <= 1'b1;
      pos_q   <= '0;
      last_q  <= bundle_i.last_idx;
    end else if (valid_q && !out_stall_i) begin
      if (at_last) begin
        valid_q <= 1'b0;
      end else begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && load_i) begin
      for (int lv = 0; lv < LEVEL_COUNT; lv++) begin
        pairs_q[lv] <= bundle_i.pairs[lv];
      end
    end
  end

  assign cur             = pairs_q[pos_q];
  assign out_valid_o     = valid_q;
  assign pyramid_level_o = LEVEL_W'(pos_q);
  assign left_low_o      = cur.l_lo;
  assign left_high_o     = cur.l_hi;
  assign right_low_o     = one_channel_i ? '0 : cur.r_lo;
  assign right_high_o    = one_channel_i ? '0 : cur.r_hi;
  assign last_of_run_o   = at_last;

`ifndef SYNTH
  // the read position never passes the last result of the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> pos_q <= last_q)
    else $error("result position past last result");

  // a taken word that is not the last keeps the buffer full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_stall_i && !at_last |=> valid_q && pos_q == $past(pos_q) + 1'b1)
    else $error("results of one frame dropped");
`endif

endmodule

// ===== hdl/minmax_peak_pyramid_builder.sv =====
// ----------------------------------------------------------------------------
// minmax_peak_pyramid_builder
// streaming min/max peak pyramid over stereo Q2.22 audio frames
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o carry one frame word (two Q2.22
//   samples and a final-frame flag); a word is taken when valid is high and
//   stall is low. output channel: out_valid_o / out_stall_i carry one result
//   word (level, quantized left/right min and max, last_of_run).
//   every 32 frames a level-0 word comes out, every 32 level-0 words also a
//   level-1 word, and so on; a final frame flushes all levels, so it causes
//   one word per level. words of one frame come out in ascending level order
//   and last_of_run marks the last of them.
//   a frame passes the input register, the window stage and the result
//   register before its first result shows on the ports.
//   throughput: one frame per cycle while the output is not stalled and frames
//   cause at most one result; a frame with k results holds the result register
//   until its k words have left, since the output port moves one word per cycle.
//   a stalled output holds its word; the pipeline behind it stops and
//   in_stall_o rises once the input register is full.
//   reset clears all fills, empties the pipeline and sets two channels.
//   cfg_we_i writes active_channels; only write it while the block is idle.
// ----------------------------------------------------------------------------
module minmax_peak_pyramid_builder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [mmpp_pkg::CHAN_W-1:0]  cfg_wdata_i,
  // frame input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  mmpp_pkg::sample_t            sample_left_i,
  input  mmpp_pkg::sample_t            sample_right_i,
  input  logic                         final_frame_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mmpp_pkg::LEVEL_W-1:0] pyramid_level_o,
  output mmpp_pkg::qval_t              left_low_o,
  output mmpp_pkg::qval_t              left_high_o,
  output mmpp_pkg::qval_t              right_low_o,
  output mmpp_pkg::qval_t              right_high_o,
  output logic                         last_of_run_o
);
  import mmpp_pkg::*;

  // active channel count, anything but one renders both channels
  logic [CHAN_W-1:0] chan_q;

  // input register
  logic    in_valid_q;
  sample_t left_q;
  sample_t right_q;
  logic    final_q;
  logic    in_ready;

  // pipeline advance, driven by the result register
  logic    en;
  stage_t  stage;
  logic    load;
  bundle_t bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= CHAN_RESET;
    end else if (cfg_we_i) begin
      chan_q <= cfg_wdata_i;
    end
  end

  // the input register takes a word when empty or when it moves on this cycle
  assign in_ready   = !in_valid_q || en;
  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      left_q  <= sample_left_i;
      right_q <= sample_right_i;
      final_q <= final_frame_i;
    end
  end

  // window min/max and quantization, registered into the window stage
  mmpp_window u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (in_valid_q),
    .sample_left_i  (left_q),
    .sample_right_i (right_q),
    .final_frame_i  (final_q),
    .stage_o        (stage)
  );

  // upper-level folding, gathers all results of the frame
  mmpp_fold u_fold (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .stage_i  (stage),
    .load_o   (load),
    .bundle_o (bundle)
  );

  // result register and per-word serializer
  mmpp_outbuf u_outbuf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .bundle_i        (bundle),
    .one_channel_i   (chan_q == CHAN_ONE),
    .en_o            (en),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pyramid_level_o (pyramid_level_o),
    .left_low_o      (left_low_o),
    .left_high_o     (left_high_o),
    .right_low_o     (right_low_o),
    .right_high_o    (right_high_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule
